### sv/fbrw_pkg.sv
// Shared types and constants for the framebuffer region writer.
// Holds beat payload structs, register indexes and field codes.
// No dependencies.
`timescale 1ns / 1ps

package fbrw_pkg;

    localparam int ADDR_BITS  = 22;
    localparam int COORD_BITS = 11;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int BASE_W     = 22;
    localparam int PITCH_W    = 13;
    localparam int CFG_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = DIM_W + PITCH_W;
    localparam int SUM_W      = ((ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W) + 1;

    localparam logic [DIM_W-1:0]   DIM_LIMIT   = DIM_W'(1) << COORD_BITS;
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 2'd3;

    // Buffer select codes.
    localparam logic [1:0] BUF_FRONT   = 2'd0;
    localparam logic [1:0] BUF_BACK    = 2'd1;
    localparam logic [1:0] BUF_AUX     = 2'd2;
    localparam logic [1:0] BUF_INVALID = 2'd3;

    // Source pixel formats; the remaining codes copy the low 16 bits.
    localparam logic [2:0] FMT_RGB565   = 3'd0;
    localparam logic [2:0] FMT_RGB555   = 3'd1;
    localparam logic [2:0] FMT_ARGB1555 = 3'd2;
    localparam logic [2:0] FMT_RGB888   = 3'd3;
    localparam logic [2:0] FMT_ARGB8888 = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_BUF = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [1:0]            buffer_select;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [DIM_W-1:0]      region_width;
        logic [DIM_W-1:0]      region_height;
        logic [2:0]            pixel_format;
        logic [31:0]           source_pixel;
    } t_in_beat;

    typedef struct packed {
        logic [ADDR_BITS-1:0] write_address;
        logic [15:0]          write_data;
        logic                 write_enable;
        logic [1:0]           status;
        logic                 region_last;
    } t_out_beat;

endpackage

### sv/fbrw_pix_conv.sv
// Pixel format converter: raw source pixel to RGB565.
// Depends on fbrw_pkg for the format codes.
`timescale 1ns / 1ps

module fbrw_pix_conv (
    input  logic [2:0]  i_format,
    input  logic [31:0] i_pixel,
    output logic [15:0] o_rgb565
);

    always_comb begin
        case (i_format) inside
            fbrw_pkg::FMT_RGB555, fbrw_pkg::FMT_ARGB1555: begin
                // Five-bit green lands in the top of the six-bit field.
                o_rgb565 = {i_pixel[14:10], i_pixel[9:5], 1'b0, i_pixel[4:0]};
            end
            fbrw_pkg::FMT_RGB888, fbrw_pkg::FMT_ARGB8888: begin
                o_rgb565 = {i_pixel[23:19], i_pixel[15:10], i_pixel[7:3]};
            end
            default: begin
                o_rgb565 = i_pixel[15:0];
            end
        endcase
    end

endmodule

### sv/framebuffer_region_writer_top.sv
// Top level of the framebuffer region writer: position counters, address
// arithmetic and the two-stage beat pipeline. Depends on fbrw_pkg and fbrw_pix_conv.
`timescale 1ns / 1ps

// Channel   | Signals                            | Direction
// ----------+------------------------------------+----------
// in        | i_in_valid, o_in_ready, i_in_data  | sink
// out       | o_out_valid, i_out_ready, o_out_data | source
// cfg       | i_cfg_we, i_cfg_index, i_cfg_data  | sink, write only
//
// One input beat is accepted per cycle unless stalled; each yields one result.
// The position counters update at the accepting edge; the row times pitch
// multiply-add sits between the stage register and the output register.
// A stalled output holds both stages; reset clears counters and valids and
// restores the row pitch to 640 and the bases to zero.

module framebuffer_region_writer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fbrw_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fbrw_pkg::t_out_beat             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fbrw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbrw_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CW = fbrw_pkg::COORD_BITS;
    localparam int DW = fbrw_pkg::DIM_W;
    localparam int SW = fbrw_pkg::SUM_W;

    // Configuration registers.
    logic [fbrw_pkg::BASE_W-1:0]  r_front_base;
    logic [fbrw_pkg::BASE_W-1:0]  r_back_base;
    logic [fbrw_pkg::BASE_W-1:0]  r_aux_base;
    logic [fbrw_pkg::PITCH_W-1:0] r_row_pitch;

    // Position counters.
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;

    // Stage register.
    logic          r_s1_valid;
    logic [1:0]    r_s1_status;
    logic [1:0]    r_s1_sel;
    logic [DW-1:0] r_s1_x;
    logic [DW-1:0] r_s1_y;
    logic [15:0]   r_s1_data;
    logic          r_s1_last;

    // Output register.
    logic                r_out_valid;
    fbrw_pkg::t_out_beat r_out;

    logic          accept;
    logic          s1_move;
    logic [DW-1:0] width_eff;
    logic [DW-1:0] height_eff;
    logic          is_err;
    logic [1:0]    err_status;
    logic          outside;
    logic [CW-1:0] col_eff;
    logic [CW-1:0] row_eff;
    logic          last_col;
    logic          last_row;
    logic [15:0]   conv_data;

    logic [fbrw_pkg::BASE_W-1:0] base_sel;
    logic [fbrw_pkg::PROD_W-1:0] row_offset;
    logic [SW-1:0]               addr_sum;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    // Front end: clamp the region, check for errors and place the pixel.
    always_comb begin
        width_eff  = (i_in_data.region_width > fbrw_pkg::DIM_LIMIT) ?
                     fbrw_pkg::DIM_LIMIT : i_in_data.region_width;
        height_eff = (i_in_data.region_height > fbrw_pkg::DIM_LIMIT) ?
                     fbrw_pkg::DIM_LIMIT : i_in_data.region_height;
        is_err     = (i_in_data.buffer_select == fbrw_pkg::BUF_INVALID) ||
                     (width_eff == '0) || (height_eff == '0);
        err_status = (i_in_data.buffer_select == fbrw_pkg::BUF_INVALID) ?
                     fbrw_pkg::ST_BAD_BUF : fbrw_pkg::ST_EMPTY;
        // A descriptor change can leave the counters outside the region.
        outside    = ({1'b0, r_col} >= width_eff) || ({1'b0, r_row} >= height_eff);
        col_eff    = outside ? '0 : r_col;
        row_eff    = outside ? '0 : r_row;
        last_col   = ({1'b0, col_eff} == (width_eff - DW'(1)));
        last_row   = ({1'b0, row_eff} == (height_eff - DW'(1)));

        if (is_err) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : (row_eff + CW'(1));
        end else begin
            n_col = col_eff + CW'(1);
            n_row = row_eff;
        end
    end

    fbrw_pix_conv u_conv (
        .i_format (i_in_data.pixel_format),
        .i_pixel  (i_in_data.source_pixel),
        .o_rgb565 (conv_data)
    );

    // Back end: base plus row times pitch plus column.
    always_comb begin
        case (r_s1_sel)
            fbrw_pkg::BUF_FRONT: base_sel = r_front_base;
            fbrw_pkg::BUF_BACK:  base_sel = r_back_base;
            default:             base_sel = r_aux_base;
        endcase
        row_offset = r_s1_y * r_row_pitch;
        addr_sum   = SW'(base_sel) + SW'(row_offset) + SW'(r_s1_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_base <= '0;
            r_back_base  <= '0;
            r_aux_base   <= '0;
            r_row_pitch  <= fbrw_pkg::PITCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbrw_pkg::REG_FRONT_BASE: r_front_base <= i_cfg_data[fbrw_pkg::BASE_W-1:0];
                fbrw_pkg::REG_BACK_BASE:  r_back_base  <= i_cfg_data[fbrw_pkg::BASE_W-1:0];
                fbrw_pkg::REG_AUX_BASE:   r_aux_base   <= i_cfg_data[fbrw_pkg::BASE_W-1:0];
                fbrw_pkg::REG_ROW_PITCH:  r_row_pitch  <= i_cfg_data[fbrw_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= is_err ? err_status : fbrw_pkg::ST_OK;
            r_s1_sel    <= i_in_data.buffer_select;
            r_s1_x      <= {1'b0, i_in_data.start_x} + {1'b0, col_eff};
            r_s1_y      <= {1'b0, i_in_data.start_y} + {1'b0, row_eff};
            r_s1_data   <= conv_data;
            r_s1_last   <= last_col && last_row;
        end
        if (s1_move) begin
            if (r_s1_status == fbrw_pkg::ST_OK) begin
                r_out.write_address <= addr_sum[fbrw_pkg::ADDR_BITS-1:0];
                r_out.write_data    <= r_s1_data;
                r_out.write_enable  <= 1'b1;
                r_out.status        <= fbrw_pkg::ST_OK;
                r_out.region_last   <= r_s1_last;
            end else begin
                r_out.write_address <= '0;
                r_out.write_data    <= '0;
                r_out.write_enable  <= 1'b0;
                r_out.status        <= r_s1_status;
                r_out.region_last   <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
